>>> hw/rtl/gke_pkg.sv
package gke_pkg;

    localparam int FEATURE_BITS_DEF = 16;

    localparam int SUM_W = 44;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam int GAMMA_W = 32;
    localparam logic signed [GAMMA_W-1:0] GAMMA_RESET = -32'sd32768;

    localparam int KV_W = 17;
    localparam logic [KV_W-1:0] KV_ONE = 17'h10000;

    localparam int ALU_X_W   = 33;
    localparam int ALU_Y_W   = 44;
    localparam int ALU_ACC_W = 76;
    localparam int ALU_CNT_W = 6;
    localparam logic [ALU_CNT_W-1:0] ALU_STEPS = 6'd33;

    localparam logic [ALU_ACC_W-1:0] UNDERFLOW_LIMIT = 76'd12 << 32;
    localparam logic [ALU_Y_W-1:0] LOG2E_Q30 = 44'd1549082005;
    localparam logic [ALU_Y_W-1:0] LN2_Q32   = 44'd2977044472;

    localparam int P_SHIFT   = 8;
    localparam int P_W       = 28;
    localparam int PROD2_W   = 59;
    localparam int LOG_SHIFT = 30;
    localparam int YV_W      = 30;
    localparam int FRAC_W    = 24;
    localparam int N_W       = 6;
    localparam int T_SHIFT   = 24;
    localparam int T_W       = 32;
    localparam int Q_SHIFT   = 32;
    localparam int R_W       = 33;
    localparam logic [R_W-1:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [N_W-1:0] N_MAX = 6'd40;

    localparam int K_W = 4;
    localparam logic [K_W-1:0] SERIES_TERMS = 4'd10;

    typedef struct packed {
        logic start;
        logic div;
    } alu_cmd_t;

    typedef struct packed {
        logic load;
        logic square;
        logic add;
        logic clear;
    } acc_ctl_t;

endpackage

>>> hw/rtl/gke_alu.sv
module gke_alu
    import gke_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  alu_cmd_t             cmd,
    input  logic [ALU_X_W-1:0]   x,
    input  logic [ALU_Y_W-1:0]   y,
    output logic                 done,
    output logic [ALU_ACC_W-1:0] acc,
    output logic [ALU_X_W-1:0]   quo
);

    logic [ALU_ACC_W-1:0] acc_reg, acc_next;
    logic [ALU_X_W-1:0]   sh_reg, sh_next;
    logic [ALU_Y_W-1:0]   opnd_reg, opnd_next;
    logic [ALU_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 div_reg, div_next;
    logic                 done_reg, done_next;

    logic [ALU_ACC_W-1:0] base;
    logic [ALU_ACC_W-1:0] addend;
    logic [ALU_ACC_W:0]   sum_ext;
    logic                 keep;

    // Multiply runs MSB first as shift and add; divide runs as restoring
    // division. Both share the one adder below.
    always_comb
    begin
        base    = {acc_reg[ALU_ACC_W-2:0], div_reg & sh_reg[ALU_X_W-1]};
        addend  = (div_reg || sh_reg[ALU_X_W-1]) ? ALU_ACC_W'(opnd_reg) : '0;
        sum_ext = {1'b0, base} + {1'b0, (div_reg ? ~addend : addend)}
                  + (ALU_ACC_W+1)'(div_reg);
        keep    = div_reg && !sum_ext[ALU_ACC_W];
    end

    always_comb
    begin
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        opnd_next = opnd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            acc_next  = '0;
            sh_next   = x;
            opnd_next = y;
            cnt_next  = ALU_STEPS;
            busy_next = 1'b1;
            div_next  = cmd.div;
        end
        else if (busy_reg)
        begin
            acc_next = keep ? base : sum_ext[ALU_ACC_W-1:0];
            sh_next  = {sh_reg[ALU_X_W-2:0], div_reg & sum_ext[ALU_ACC_W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ALU_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            div_reg  <= div_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        sh_reg   <= sh_next;
        opnd_reg <= opnd_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;
    assign quo  = sh_reg;

endmodule

>>> hw/rtl/gke_accum.sv
module gke_accum
    import gke_pkg::*;
#(
    parameter int FEATURE_BITS = FEATURE_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  acc_ctl_t                       ctl,
    input  logic signed [FEATURE_BITS-1:0] feature_a,
    input  logic signed [FEATURE_BITS-1:0] feature_b,
    output logic [SUM_W-1:0]               sum,
    output logic                           overflow
);

    localparam int DIFF_W = FEATURE_BITS + 1;
    localparam int SQ_W   = 2 * FEATURE_BITS + 1;
    localparam int ADD_W  = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

    logic signed [DIFF_W-1:0]   diff_reg, diff_next;
    logic [SQ_W-1:0]            sq_reg, sq_next;
    logic signed [2*DIFF_W-1:0] prod;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic                       ovf_reg, ovf_next;
    logic [ADD_W-1:0]           add_sum;

    always_comb
    begin
        diff_next = DIFF_W'(feature_a) - DIFF_W'(feature_b);
        prod      = diff_reg * diff_reg;
        sq_next   = prod[SQ_W-1:0];
        add_sum   = ADD_W'(sum_reg) + ADD_W'(sq_reg);

        sum_next = sum_reg;
        ovf_next = ovf_reg;
        if (ctl.clear)
        begin
            sum_next = '0;
            ovf_next = 1'b0;
        end
        else if (ctl.add)
        begin
            if (add_sum > ADD_W'(SUM_MAX))
            begin
                sum_next = SUM_MAX;
                ovf_next = 1'b1;
            end
            else
            begin
                sum_next = add_sum[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            diff_reg <= diff_next;
        end
        if (ctl.square)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sum      = sum_reg;
    assign overflow = ovf_reg;

endmodule

>>> hw/rtl/gaussian_kernel_element.sv
// Channel   Direction  Handshake                    Payload
// feature   in         feature_valid/feature_ready  feature_a, feature_b, last_coord
// kernel    out        kernel_valid/kernel_ready    kernel_value, saturated
// gamma     in         gamma_we (no wait)           gamma_wdata
//
// Each coordinate transfer runs through capture, square and saturating add before the next is taken.
// A last coordinate then runs the exponential on one shared shift-add unit:
// 3 multiplies plus 10 multiply/divide pairs.
// Special cases (zero sum, non-negative gamma, underflow) skip the series; the first two skip the unit.
// Reset clears the accumulator, sets gamma to -0.5 and empties the output register.
// A waiting result does not block new coordinates; only the next result waits for it.
module gaussian_kernel_element
    import gke_pkg::*;
#(
    parameter int FEATURE_BITS = FEATURE_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           feature_valid,
    output logic                           feature_ready,
    input  logic signed [FEATURE_BITS-1:0] feature_a,
    input  logic signed [FEATURE_BITS-1:0] feature_b,
    input  logic                           last_coord,
    output logic                           kernel_valid,
    input  logic                           kernel_ready,
    output logic [KV_W-1:0]                kernel_value,
    output logic                           saturated,
    input  logic                           gamma_we,
    input  logic signed [GAMMA_W-1:0]      gamma_wdata
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQ     = 4'd1;
    localparam logic [3:0] S_ADD    = 4'd2;
    localparam logic [3:0] S_PREP   = 4'd3;
    localparam logic [3:0] S_PROD   = 4'd4;
    localparam logic [3:0] S_LOG    = 4'd5;
    localparam logic [3:0] S_FRAC   = 4'd6;
    localparam logic [3:0] S_SSTART = 4'd7;
    localparam logic [3:0] S_SMUL   = 4'd8;
    localparam logic [3:0] S_SDIV   = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0]                 state_reg, state_next;
    logic signed [GAMMA_W-1:0]  gamma_reg, gamma_next;
    logic                       last_reg, last_next;
    logic                       sat_reg, sat_next;
    logic [KV_W-1:0]            kv_reg, kv_next;
    logic [N_W-1:0]             n_reg, n_next;
    logic [T_W-1:0]             t_reg, t_next;
    logic [R_W-1:0]             r_reg, r_next;
    logic [K_W-1:0]             k_reg, k_next;
    logic                       kernel_valid_reg, kernel_valid_next;
    logic [KV_W-1:0]            kernel_value_reg, kernel_value_next;
    logic                       saturated_reg, saturated_next;

    acc_ctl_t                   acc_ctl;
    logic [SUM_W-1:0]           acc_sum;
    logic                       acc_ovf;

    alu_cmd_t                   alu_cmd;
    logic [ALU_X_W-1:0]         alu_x;
    logic [ALU_Y_W-1:0]         alu_y;
    logic                       alu_done;
    logic [ALU_ACC_W-1:0]       alu_acc;
    logic [ALU_X_W-1:0]         alu_quo;

    logic [GAMMA_W-1:0]         gamma_mag;
    logic [PROD2_W:0]           y_round;
    logic [YV_W-1:0]            y_val;
    logic [6:0]                 fin_sh;
    logic [63:0]                fin_tmp;
    logic [63:0]                fin_val;
    logic [KV_W-1:0]            fin_kv;

    gke_accum #(
        .FEATURE_BITS (FEATURE_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (acc_ctl),
        .feature_a (feature_a),
        .feature_b (feature_b),
        .sum       (acc_sum),
        .overflow  (acc_ovf)
    );

    gke_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (alu_cmd),
        .x     (alu_x),
        .y     (alu_y),
        .done  (alu_done),
        .acc   (alu_acc),
        .quo   (alu_quo)
    );

    always_comb
    begin
        gamma_mag = GAMMA_W'(-gamma_reg);
        y_round   = {1'b0, alu_acc[PROD2_W-1:0]} + ((PROD2_W+1)'(1) << (LOG_SHIFT - 1));
        y_val     = y_round[LOG_SHIFT+YV_W-1:LOG_SHIFT];
        fin_sh    = 7'(n_reg) + 7'd16;
        fin_tmp   = 64'(r_reg) + (64'd1 << (fin_sh - 7'd1));
        fin_val   = fin_tmp >> fin_sh;
        fin_kv    = (n_reg > N_MAX) ? '0 : fin_val[KV_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        gamma_next        = gamma_we ? gamma_wdata : gamma_reg;
        last_next         = last_reg;
        sat_next          = sat_reg;
        kv_next           = kv_reg;
        n_next            = n_reg;
        t_next            = t_reg;
        r_next            = r_reg;
        k_next            = k_reg;
        kernel_valid_next = kernel_valid_reg && !kernel_ready;
        kernel_value_next = kernel_value_reg;
        saturated_next    = saturated_reg;
        acc_ctl           = '0;
        alu_cmd           = '0;
        alu_x             = '0;
        alu_y             = '0;
        feature_ready     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                feature_ready = 1'b1;
                if (feature_valid)
                begin
                    acc_ctl.load = 1'b1;
                    last_next    = last_coord;
                    state_next   = S_SQ;
                end
            end
            S_SQ:
            begin
                acc_ctl.square = 1'b1;
                state_next     = S_ADD;
            end
            S_ADD:
            begin
                acc_ctl.add = 1'b1;
                state_next  = last_reg ? S_PREP : S_IDLE;
            end
            S_PREP:
            begin
                sat_next      = acc_ovf;
                acc_ctl.clear = 1'b1;
                if (!gamma_reg[GAMMA_W-1] || acc_sum == '0)
                begin
                    kv_next    = KV_ONE;
                    state_next = S_OUT;
                end
                else
                begin
                    alu_cmd.start = 1'b1;
                    alu_x         = ALU_X_W'(gamma_mag);
                    alu_y         = ALU_Y_W'(acc_sum);
                    state_next    = S_PROD;
                end
            end
            S_PROD:
            begin
                if (alu_done)
                begin
                    if (alu_acc > UNDERFLOW_LIMIT)
                    begin
                        kv_next    = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        alu_cmd.start = 1'b1;
                        alu_x         = ALU_X_W'(alu_acc[P_SHIFT+P_W-1:P_SHIFT]);
                        alu_y         = LOG2E_Q30;
                        state_next    = S_LOG;
                    end
                end
            end
            S_LOG:
            begin
                if (alu_done)
                begin
                    n_next        = y_val[FRAC_W+N_W-1:FRAC_W];
                    alu_cmd.start = 1'b1;
                    alu_x         = ALU_X_W'(y_val[FRAC_W-1:0]);
                    alu_y         = LN2_Q32;
                    state_next    = S_FRAC;
                end
            end
            S_FRAC:
            begin
                if (alu_done)
                begin
                    t_next     = alu_acc[T_SHIFT+T_W-1:T_SHIFT];
                    r_next     = ONE_Q32;
                    k_next     = SERIES_TERMS;
                    state_next = S_SSTART;
                end
            end
            S_SSTART:
            begin
                alu_cmd.start = 1'b1;
                alu_x         = r_reg;
                alu_y         = ALU_Y_W'(t_reg);
                state_next    = S_SMUL;
            end
            S_SMUL:
            begin
                if (alu_done)
                begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.div   = 1'b1;
                    alu_x         = alu_acc[Q_SHIFT+ALU_X_W-1:Q_SHIFT];
                    alu_y         = ALU_Y_W'(k_reg);
                    state_next    = S_SDIV;
                end
            end
            S_SDIV:
            begin
                if (alu_done)
                begin
                    r_next = ONE_Q32 - alu_quo;
                    if (k_reg == K_W'(1))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        k_next     = k_reg - 1'b1;
                        state_next = S_SSTART;
                    end
                end
            end
            S_FIN:
            begin
                kv_next    = fin_kv;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!kernel_valid_reg || kernel_ready)
                begin
                    kernel_valid_next = 1'b1;
                    kernel_value_next = kv_reg;
                    saturated_next    = sat_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            gamma_reg        <= GAMMA_RESET;
            last_reg         <= 1'b0;
            kernel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            gamma_reg        <= gamma_next;
            last_reg         <= last_next;
            kernel_valid_reg <= kernel_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg          <= sat_next;
        kv_reg           <= kv_next;
        n_reg            <= n_next;
        t_reg            <= t_next;
        r_reg            <= r_next;
        k_reg            <= k_next;
        kernel_value_reg <= kernel_value_next;
        saturated_reg    <= saturated_next;
    end

    assign kernel_valid = kernel_valid_reg;
    assign kernel_value = kernel_value_reg;
    assign saturated    = saturated_reg;

`ifndef SYNTHESIS
    // A new result is loaded only from the output state.
    a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(kernel_valid) |-> $past(state_reg == S_OUT))
        else $error("result appeared outside the output state");

    a_kernel_range: assert property (@(posedge clk) disable iff (!rst_n)
        kernel_valid |-> kernel_value <= KV_ONE)
        else $error("kernel value above one");

    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> (state_reg == S_PROD || state_reg == S_LOG || state_reg == S_FRAC
                      || state_reg == S_SMUL || state_reg == S_SDIV))
        else $error("shared unit finished while nobody waited");

    a_series_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SMUL || state_reg == S_SDIV) |-> (k_reg >= K_W'(1)
                                                          && k_reg <= SERIES_TERMS))
        else $error("series term index out of range");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP) |=> (acc_sum == '0 && !acc_ovf))
        else $error("accumulator not cleared after last coordinate");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import gke_pkg::*;

    typedef struct packed {
        logic [KV_W-1:0] value;
        logic            saturated;
    } kernel_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      feature_valid = 1'b0;
    logic                      feature_ready;
    logic signed [15:0]        feature_a = '0;
    logic signed [15:0]        feature_b = '0;
    logic                      last_coord = 1'b0;
    logic                      kernel_valid;
    logic                      kernel_ready = 1'b0;
    logic [KV_W-1:0]           kernel_value;
    logic                      saturated;
    logic                      gamma_we = 1'b0;
    logic signed [GAMMA_W-1:0] gamma_wdata = '0;

    logic signed [GAMMA_W-1:0] scale_gamma = GAMMA_RESET;
    logic [SUM_W-1:0]          dist_sum = '0;
    logic                      dist_overflow = 1'b0;
    kernel_result_t            pending_kernels[$];

    int send_idle_pct = 9;
    int recv_idle_pct = 56;
    int kernel_hold_left = 0;
    int fail_count = 0;
    int coords_sent = 0;
    int kernels_checked = 0;
    int zero_kernels = 0;
    int saturated_kernels = 0;

    gaussian_kernel_element dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .feature_valid (feature_valid),
        .feature_ready (feature_ready),
        .feature_a     (feature_a),
        .feature_b     (feature_b),
        .last_coord    (last_coord),
        .kernel_valid  (kernel_valid),
        .kernel_ready  (kernel_ready),
        .kernel_value  (kernel_value),
        .saturated     (saturated),
        .gamma_we      (gamma_we),
        .gamma_wdata   (gamma_wdata)
    );

    always #1 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // The exponential is evaluated as a power of two times a truncated series for the fraction.
    function automatic logic [KV_W-1:0] rbf_kernel_of(input logic [SUM_W-1:0] sum,
                                                      input logic signed [GAMMA_W-1:0] g);
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned yv;
        longint unsigned frac;
        longint unsigned tv;
        longint unsigned rv;
        longint unsigned rounded;
        int unsigned     shift;
        if (g > 0)
            return KV_ONE;
        mag = -longint'(g);
        if (mag == 0 || sum == 0)
            return KV_ONE;
        if (sum > (64'd12 << 32) / mag)
            return '0;
        prod = mag * sum;
        yv = ((prod >> 8) * LOG2E_Q30 + (64'd1 << 29)) >> 30;
        shift = 32'(yv >> 24);
        frac = yv & 64'hFF_FFFF;
        tv = (frac * LN2_Q32) >> 24;
        rv = 64'd1 << 32;
        for (int k = int'(SERIES_TERMS); k >= 1; k--)
            rv = (64'd1 << 32) - ((tv * rv) >> 32) / k;
        if (shift > 40)
            return '0;
        rounded = (rv + (64'd1 << (15 + shift))) >> (16 + shift);
        return rounded[KV_W-1:0];
    endfunction

    task automatic send_coord(input logic signed [15:0] a, input logic signed [15:0] b,
                              input logic last);
        longint          diff;
        longint unsigned sq;
        kernel_result_t  res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            feature_valid <= 1'b0;
            @(negedge clk);
        end
        feature_valid <= 1'b1;
        feature_a <= a;
        feature_b <= b;
        last_coord <= last;
        do
            @(posedge clk);
        while (!feature_ready);
        coords_sent++;
        diff = a - b;
        sq = (diff < 0) ? -diff * -diff : diff * diff;
        if (sq > SUM_MAX - dist_sum)
        begin
            dist_sum = SUM_MAX;
            dist_overflow = 1'b1;
        end
        else
        begin
            dist_sum = dist_sum + SUM_W'(sq);
        end
        if (last)
        begin
            res.value = rbf_kernel_of(dist_sum, scale_gamma);
            res.saturated = dist_overflow;
            pending_kernels.push_back(res);
            dist_sum = '0;
            dist_overflow = 1'b0;
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        feature_valid <= 1'b0;
        while (pending_kernels.size() != 0)
            @(negedge clk);
        repeat (850) @(negedge clk);
    endtask

    task automatic write_gamma(input logic signed [GAMMA_W-1:0] value);
        drain_results();
        gamma_we <= 1'b1;
        gamma_wdata <= value;
        @(negedge clk);
        gamma_we <= 1'b0;
        scale_gamma = value;
    endtask

    always @(negedge clk)
    begin
        if (kernel_hold_left > 0)
        begin
            kernel_ready <= 1'b0;
            kernel_hold_left = kernel_hold_left - 1;
        end
        else
        begin
            kernel_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        kernel_result_t want;
        if (rst_n && kernel_valid && kernel_ready)
        begin
            if (pending_kernels.size() == 0)
            begin
                $display("%0t: unexpected kernel transfer, value %0d saturated %0b",
                         $time, kernel_value, saturated);
                fail_count++;
            end
            else
            begin
                want = pending_kernels.pop_front();
                kernels_checked++;
                if (want.value == 0)
                    zero_kernels++;
                if (want.saturated)
                    saturated_kernels++;
                if (kernel_value !== want.value)
                begin
                    $display("%0t: kernel_value expected %0d, got %0d",
                             $time, want.value, kernel_value);
                    fail_count++;
                end
                if (saturated !== want.saturated)
                begin
                    $display("%0t: saturated expected %0b, got %0b",
                             $time, want.saturated, saturated);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_reset_scale();
        send_coord(16'sd100, 16'sd100, 1'b1);
        send_coord(16'sd1, 16'sd0, 1'b1);
        send_coord(16'sd32767, -16'sd32768, 1'b1);
        send_coord(-16'sd32768, 16'sd32767, 1'b1);
        send_coord(-16'sd32768, -16'sd32768, 1'b0);
        send_coord(16'sd32767, 16'sd32767, 1'b0);
        send_coord(16'sd256, 16'sd0, 1'b1);
        send_coord(16'sd0, -16'sd256, 1'b0);
        send_coord(16'sd0, 16'sd256, 1'b1);
    endtask

    task automatic test_zero_and_positive_scale();
        write_gamma(32'sd0);
        send_coord(16'sd32767, -16'sd32768, 1'b0);
        send_coord(-16'sd32768, 16'sd32767, 1'b1);
        write_gamma(32'sh7FFF_FFFF);
        send_coord(16'sd256, 16'sd0, 1'b1);
        write_gamma(32'sd1);
        send_coord(16'sd256, 16'sd0, 1'b1);
        write_gamma(32'sh8000_0000);
        send_coord(16'sd1, 16'sd0, 1'b1);
        send_coord(16'sd5, 16'sd0, 1'b1);
    endtask

    task automatic test_underflow_boundary();
        write_gamma(-32'sd65536);
        send_coord(16'sd512, 16'sd0, 1'b0);
        send_coord(16'sd0, 16'sd512, 1'b0);
        send_coord(16'sd512, 16'sd0, 1'b1);
        send_coord(16'sd0, 16'sd512, 1'b0);
        send_coord(16'sd512, 16'sd0, 1'b0);
        send_coord(16'sd513, 16'sd0, 1'b1);
        send_coord(16'sd0, 16'sd0, 1'b1);
    endtask

    // About 4097 full-scale differences are needed before the distance sum saturates.
    task automatic test_accumulator_saturation();
        write_gamma(-32'sd1);
        for (int i = 0; i < 4100; i++)
            send_coord(16'sd32767, -16'sd32768, i == 4099);
        send_coord(16'sd3, 16'sd0, 1'b1);
    endtask

    task automatic test_output_backpressure();
        write_gamma(-32'sd4096);
        send_idle_pct = 0;
        kernel_hold_left = 3000;
        for (int i = 0; i < 8; i++)
        begin
            send_coord(16'($urandom), 16'($urandom_range(0, 64)), 1'b0);
            send_coord(16'($urandom_range(0, 255)), 16'($urandom), 1'b1);
        end
    endtask

    task automatic send_random_pair(output int unsigned sent);
        int unsigned        len;
        int unsigned        style;
        int                 offset;
        logic signed [15:0] a;
        logic signed [15:0] b;
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 48);
        style = $urandom_range(3);
        for (int unsigned i = 0; i < len; i++)
        begin
            a = 16'($urandom);
            case (style)
                0: b = 16'($urandom);
                1:
                begin
                    offset = int'($urandom_range(0, 64)) - 32;
                    b = 16'(a + offset);
                end
                2:
                begin
                    a = 16'(int'($urandom_range(0, 1024)) - 512);
                    b = 16'(int'($urandom_range(0, 1024)) - 512);
                end
                default: b = ($urandom_range(3) == 0) ? 16'(a + 1) : a;
            endcase
            send_coord(a, b, i == len - 1);
        end
        sent = len;
    endtask

    task automatic test_random_pairs();
        int                 phase_send[3] = '{9, 56, 0};
        int                 phase_recv[3] = '{56, 9, 0};
        int unsigned        block_items;
        int unsigned        sent;
        logic signed [31:0] g;
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = phase_send[p];
            recv_idle_pct = phase_recv[p];
            for (int blk = 0; blk < 4; blk++)
            begin
                case ($urandom_range(5))
                    0: g = $urandom | 32'h8000_0000;
                    1: g = 0 - $urandom_range(1, 255);
                    2: g = 0 - $urandom_range(256, 65536);
                    3: g = 0 - $urandom_range(65537, 1 << 24);
                    4: g = GAMMA_RESET;
                    default: g = 0;
                endcase
                write_gamma(g);
                block_items = 0;
                while (block_items < 65)
                begin
                    send_random_pair(sent);
                    block_items += sent;
                end
            end
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_scale();
        test_zero_and_positive_scale();
        test_underflow_boundary();
        test_accumulator_saturation();
        test_output_backpressure();
        test_random_pairs();
        drain_results();
        $display("Sent %0d coordinates; checked %0d kernel values.", coords_sent,
                 kernels_checked);
        $display("Of those, %0d underflowed to zero and %0d had a saturated distance sum.",
                 zero_kernels, saturated_kernels);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/gke_pkg.sv
hw/rtl/gke_alu.sv
hw/rtl/gke_accum.sv
hw/rtl/gaussian_kernel_element.sv
tb/tb.sv
